/* sv/csh_pkg.sv */
`default_nettype none
package csh_pkg;

  // request kinds
  localparam logic [1:0] KIND_DOWN  = 2'd0;
  localparam logic [1:0] KIND_UP    = 2'd1;
  localparam logic [1:0] KIND_CLEAN = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_BLOCK = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOEFF = 2'd3;

  // register indexes (paddr[2])
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_INIT  = 1'b1;

  localparam int OWNER_W = 8;
  localparam int UNITS_W = 16;
  localparam int ENTRY_W = OWNER_W + UNITS_W;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CMP = 9'b000000100,
    S_DECIDE   = 9'b000001000,
    S_FIRST    = 9'b000010000,
    S_UP_ACT   = 9'b000100000,
    S_COMP_RD  = 9'b001000000,
    S_COMP_WR  = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    ADDR_IDX  = 2'd0,
    ADDR_NEXT = 2'd1,
    ADDR_ZERO = 2'd2
  } addr_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_DOWN_HIT = 3'd1,
    ACT_DOWN_NEW = 3'd2,
    ACT_UP       = 3'd3,
    ACT_CLEAN    = 3'd4,
    ACT_REPORT   = 3'd5
  } act_t;

  typedef struct packed {
    logic      load;
    logic      rd;
    addr_sel_t addr_sel;
    logic      hit;
    logic      idx_inc;
    logic      take_first;
    act_t      act;
    logic [1:0] code;
    logic      cwr;
    logic      dec_entries;
    logic      push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       owner_ok;
    logic       avail_zero;
    logic       below_limit;
    logic       scan_end;
    logic       match;
    logic       found;
    logic       table_full;
    logic       entries_zero;
    logic       units_le1;
    logic       comp_end;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* sv/csh_ram.sv */
`default_nettype none
module csh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* sv/csh_ctrl.sv */
`default_nettype none
module csh_ctrl
  import csh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end || !sts.owner_ok) begin
          state_next = S_DECIDE;
        end else begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = ADDR_IDX;
          state_next   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.hit    = 1'b1;
          state_next = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        state_next = S_FINISH;
        cmd.act    = ACT_REPORT;
        cmd.code   = ST_NOEFF;
        if (sts.owner_ok) begin
          case (sts.kind)
            KIND_DOWN: begin
              if (sts.avail_zero) begin
                cmd.code = ST_BLOCK;
              end else if (sts.found) begin
                cmd.act = ACT_DOWN_HIT;
              end else if (!sts.table_full) begin
                cmd.act = ACT_DOWN_NEW;
              end else begin
                cmd.code = ST_FULL;
              end
            end
            KIND_UP: begin
              if (sts.below_limit) begin
                if (sts.found) begin
                  cmd.act = ACT_UP;
                  if (sts.units_le1) begin
                    state_next = S_COMP_RD;
                  end
                end else if (sts.entries_zero) begin
                  cmd.act = ACT_UP;
                end else begin
                  // no entry of its own: take from the oldest holder
                  cmd.act      = ACT_NONE;
                  cmd.rd       = 1'b1;
                  cmd.addr_sel = ADDR_ZERO;
                  state_next   = S_FIRST;
                end
              end
            end
            KIND_CLEAN: begin
              if (sts.found) begin
                cmd.act    = ACT_CLEAN;
                state_next = S_COMP_RD;
              end
            end
            default: begin
              cmd.code = ST_NOEFF;
            end
          endcase
        end
      end
      S_FIRST: begin
        cmd.take_first = 1'b1;
        state_next     = S_UP_ACT;
      end
      S_UP_ACT: begin
        cmd.act    = ACT_UP;
        state_next = sts.units_le1 ? S_COMP_RD : S_FINISH;
      end
      S_COMP_RD: begin
        if (sts.comp_end) begin
          cmd.dec_entries = 1'b1;
          state_next      = S_FINISH;
        end else begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = ADDR_NEXT;
          state_next   = S_COMP_WR;
        end
      end
      S_COMP_WR: begin
        cmd.cwr     = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_COMP_RD;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* sv/csh_dp.sv */
`default_nettype none
module csh_dp
  import csh_pkg::*;
#(
  parameter int HOLDERS = 16,
  parameter int OWNERS  = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  input  wire logic [1:0]         in_kind,
  input  wire logic [OWNER_W-1:0] in_owner,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [1:0]         out_status,
  output logic                    out_wake,
  output logic      [UNITS_W-1:0] out_avail,
  output logic      [UNITS_W-1:0] out_held
);
  localparam int AW = (HOLDERS > 1) ? $clog2(HOLDERS) : 1;
  localparam int CW = $clog2(HOLDERS + 1);

  logic [UNITS_W-1:0] limit, init_avail, avail;
  logic [CW-1:0]      entries, idx, idx_p1;
  logic [AW-1:0]      pos;
  logic               found, tgt;
  logic [UNITS_W-1:0] units, units_inc, units_dec;
  logic [OWNER_W-1:0] tgt_owner, owner;
  logic [1:0]         kind;
  logic [1:0]         res_status;
  logic               res_wake;
  logic [UNITS_W-1:0] res_held;
  logic [UNITS_W:0]   refill;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [OWNER_W-1:0] rd_owner;
  logic [UNITS_W-1:0] rd_units;

  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INIT) ? {16'd0, init_avail} : {16'd0, limit};

  assign rd_owner  = rdata[OWNER_W-1:0];
  assign rd_units  = rdata[ENTRY_W-1:OWNER_W];
  assign idx_p1    = idx + CW'(1);
  assign units_inc = (units == '1) ? units : units + UNITS_W'(1);
  assign units_dec = units - UNITS_W'(1);
  assign refill    = {1'b0, avail} + {1'b0, units};

  always_comb begin
    sts.kind         = kind;
    sts.owner_ok     = ({9'd0, owner} < 17'(OWNERS));
    sts.avail_zero   = (avail == '0);
    sts.below_limit  = (avail < limit);
    sts.scan_end     = (idx == entries);
    sts.match        = (rd_owner == owner);
    sts.found        = found;
    sts.table_full   = (entries == CW'(HOLDERS));
    sts.entries_zero = (entries == '0);
    sts.units_le1    = (units <= UNITS_W'(1));
    sts.comp_end     = (idx_p1 >= entries);
    sts.out_busy     = out_valid && !out_ready;
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_IDX:  raddr = idx[AW-1:0];
      ADDR_NEXT: raddr = idx_p1[AW-1:0];
      ADDR_ZERO: raddr = '0;
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {units_inc, tgt_owner};
    if (cmd.cwr) begin
      // compaction: entry moves down one place
      we    = 1'b1;
      waddr = idx[AW-1:0];
      wdata = rdata;
    end else begin
      case (cmd.act)
        ACT_DOWN_HIT: begin
          we = 1'b1;
        end
        ACT_DOWN_NEW: begin
          we    = 1'b1;
          waddr = entries[AW-1:0];
          wdata = {UNITS_W'(1), owner};
        end
        ACT_UP: begin
          we    = tgt && (units > UNITS_W'(1));
          wdata = {units_dec, tgt_owner};
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  csh_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HOLDERS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= UNITS_W'(1);
      init_avail <= '0;
      avail      <= '0;
      entries    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_INIT) begin
          init_avail <= pwdata[UNITS_W-1:0];
          avail      <= pwdata[UNITS_W-1:0];
        end else begin
          limit <= pwdata[UNITS_W-1:0];
        end
      end
      case (cmd.act)
        ACT_DOWN_HIT: avail <= avail - UNITS_W'(1);
        ACT_DOWN_NEW: begin
          avail   <= avail - UNITS_W'(1);
          entries <= entries + CW'(1);
        end
        ACT_UP: avail <= avail + UNITS_W'(1);
        ACT_CLEAN: begin
          if (units != '0) begin
            avail <= (refill > {1'b0, limit}) ? limit : refill[UNITS_W-1:0];
          end
        end
        default: begin
        end
      endcase
      if (cmd.dec_entries) begin
        entries <= entries - CW'(1);
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind  <= in_kind;
      owner <= in_owner;
      idx   <= '0;
      found <= 1'b0;
      tgt   <= 1'b0;
    end
    if (cmd.hit) begin
      found     <= 1'b1;
      tgt       <= 1'b1;
      pos       <= idx[AW-1:0];
      units     <= rd_units;
      tgt_owner <= rd_owner;
    end
    if (cmd.take_first) begin
      tgt       <= 1'b1;
      pos       <= '0;
      units     <= rd_units;
      tgt_owner <= rd_owner;
    end
    if (cmd.idx_inc) begin
      idx <= idx_p1;
    end
    case (cmd.act)
      ACT_DOWN_HIT: begin
        res_status <= ST_DONE;
        res_wake   <= 1'b0;
        res_held   <= units_inc;
      end
      ACT_DOWN_NEW: begin
        res_status <= ST_DONE;
        res_wake   <= 1'b0;
        res_held   <= UNITS_W'(1);
      end
      ACT_UP: begin
        res_status <= ST_DONE;
        res_wake   <= 1'b1;
        res_held   <= (found && (units > UNITS_W'(1))) ? units_dec : '0;
        idx        <= CW'(pos);
      end
      ACT_CLEAN: begin
        res_status <= ST_DONE;
        res_wake   <= (units != '0);
        res_held   <= '0;
        idx        <= CW'(pos);
      end
      ACT_REPORT: begin
        res_status <= cmd.code;
        res_wake   <= 1'b0;
        res_held   <= found ? units : '0;
      end
      default: begin
      end
    endcase
    if (cmd.push) begin
      out_status <= res_status;
      out_wake   <= res_wake;
      out_avail  <= avail;
      out_held   <= res_held;
    end
  end
endmodule
`default_nettype wire

/* sv/counting_semaphore_with_holders.sv */
// a transaction scans the holder table entry by entry until a match or the table end;
//   an up with no own entry first reads the oldest holder, and removing an entry
//   moves each later entry down one place
// one transaction at a time: the next is taken only after the result is issued,
//   and later while a previous result waits on m_tready
// reset (synchronous): limit 1, available 0, holder table empty, no result pending
`default_nettype none
module counting_semaphore_with_holders
  import csh_pkg::*;
#(
  parameter int HOLDERS = 16,
  parameter int OWNERS  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // owner[7:0]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // available_now[15:0], owner_held[31:16]
  output logic      [2:0]  m_tuser    // status[1:0], wake[2]
);
  cmd_t               cmd;
  sts_t               sts;
  logic [1:0]         out_status;
  logic               out_wake;
  logic [UNITS_W-1:0] out_avail, out_held;

  assign pready  = 1'b1;
  assign m_tdata = {out_held, out_avail};
  assign m_tuser = {out_wake, out_status};

  csh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  csh_dp #(
    .HOLDERS(HOLDERS),
    .OWNERS (OWNERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_kind   (s_tuser),
    .in_owner  (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(out_status),
    .out_wake  (out_wake),
    .out_avail (out_avail),
    .out_held  (out_held)
  );
endmodule
`default_nettype wire

/* tb/counting_semaphore_with_holders_test.sv */
`default_nettype none
module counting_semaphore_with_holders_test;
  import csh_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] owner;
  } sem_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        wake;
    logic [15:0] avail;
    logic [15:0] held;
  } sem_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // owner[7:0]
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // available_now[15:0], owner_held[31:16]
  logic [2:0]  m_tuser;        // status[1:0], wake[2]

  counting_semaphore_with_holders i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // semaphore mirror
  logic [15:0] sem_limit = 16'd1;
  logic [15:0] sem_avail = 16'd0;
  logic [7:0]  tbl_owner [TBL_DEPTH];
  logic [15:0] tbl_units [TBL_DEPTH];
  int          tbl_count = 0;

  sem_request_t pending_requests[$];
  sem_result_t  expected_results[$];

  int unsigned issued_count = 0;
  int unsigned taken_count = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned settings_count = 0;
  int unsigned status_tally [4] = '{0, 0, 0, 0};
  int unsigned wake_tally = 0;

  logic bulk_mode = 1'b0;
  int   hold_request = 0;

  function automatic int find_holder(input logic [7:0] who);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_owner[i] == who) return i;
    return -1;
  endfunction

  // remove an entry and close the gap, keeping acquisition order
  task automatic drop_holder(input int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_owner[i] = tbl_owner[i + 1];
      tbl_units[i] = tbl_units[i + 1];
    end
    tbl_count--;
  endtask

  task automatic step_semaphore(input logic [1:0] kind, input logic [7:0] who);
    sem_result_t r;
    int          pos;
    logic [16:0] sum;
    r.status = ST_NOEFF;
    r.wake = 1'b0;
    r.held = '0;
    case (kind)
      KIND_DOWN: begin
        if (sem_avail == 0) begin
          r.status = ST_BLOCK;
        end else begin
          pos = find_holder(who);
          if (pos < 0 && tbl_count < TBL_DEPTH) begin
            pos = tbl_count;
            tbl_owner[pos] = who;
            tbl_units[pos] = '0;
            tbl_count++;
          end
          if (pos < 0) begin
            r.status = ST_FULL;
          end else begin
            if (tbl_units[pos] != 16'hffff) tbl_units[pos] = tbl_units[pos] + 1'b1;
            sem_avail = sem_avail - 1'b1;
            r.status = ST_DONE;
          end
        end
      end
      KIND_UP: begin
        if (sem_avail < sem_limit) begin
          sem_avail = sem_avail + 1'b1;
          pos = find_holder(who);
          // a stranger's release is charged to the oldest holder
          if (pos < 0 && tbl_count > 0) pos = 0;
          if (pos >= 0) begin
            if (tbl_units[pos] != 0) tbl_units[pos] = tbl_units[pos] - 1'b1;
            if (tbl_units[pos] == 0) drop_holder(pos);
          end
          r.wake = 1'b1;
          r.status = ST_DONE;
        end
      end
      KIND_CLEAN: begin
        pos = find_holder(who);
        if (pos >= 0) begin
          if (tbl_units[pos] != 0) begin
            sum = sem_avail + tbl_units[pos];
            sem_avail = (sum > sem_limit) ? sem_limit : sum[15:0];
            r.wake = 1'b1;
          end
          drop_holder(pos);
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    pos = find_holder(who);
    if (pos >= 0) r.held = tbl_units[pos];
    r.avail = sem_avail;
    status_tally[r.status]++;
    if (r.wake) wake_tally++;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s mismatch, got 0x%0h expected 0x%0h", results_seen, what, got,
             want);
    error_count++;
  endtask

  // driver
  int           gap_left = 0;
  int           drv_calm = 0;
  sem_request_t drv_req;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        step_semaphore(s_tuser, s_tdata);
        taken_count++;
        if (drv_calm > 0) drv_calm--;
        else if ($urandom_range(0, 99) < 3) drv_calm = $urandom_range(20, 50);
        gap_left = (bulk_mode || drv_calm > 0) ? 0 : pick_gap();
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          drv_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= drv_req.owner;
          s_tuser <= drv_req.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver back-pressure
  int          hold_left = 0;
  int          stall_left = 0;
  int          mon_calm = 0;
  int          mon_roll;
  logic        ready_next;
  sem_result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", m_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser[1:0] != want.status) report_mismatch("status", m_tuser[1:0], want.status);
          if (m_tuser[2] != want.wake) report_mismatch("wake", m_tuser[2], want.wake);
          if (m_tdata[15:0] != want.avail)
            report_mismatch("available_now", m_tdata[15:0], want.avail);
          if (m_tdata[31:16] != want.held)
            report_mismatch("owner_held", m_tdata[31:16], want.held);
        end
        results_seen++;
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (bulk_mode || mon_calm > 0) begin
        if (mon_calm > 0) mon_calm--;
        ready_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        mon_roll = $urandom_range(0, 99);
        ready_next = 1'b1;
        if (mon_roll < 3) begin
          mon_calm = $urandom_range(20, 60);
        end else if (mon_roll < 20) begin
          stall_left = $urandom_range(0, 2);
          ready_next = 1'b0;
        end else if (mon_roll < 23) begin
          stall_left = $urandom_range(10, 40);
          ready_next = 1'b0;
        end
      end
      m_tready <= ready_next;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LIMIT) begin
      sem_limit = value;
    end else begin
      sem_avail = value;
    end
  endtask

  task automatic set_counts(input logic [15:0] lim, input logic [15:0] init);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_INIT, init);
    settings_count++;
  endtask

  task automatic queue_request(input logic [1:0] kind, input logic [7:0] who);
    sem_request_t req;
    req.kind = kind;
    req.owner = who;
    pending_requests.push_back(req);
    issued_count++;
  endtask

  task automatic wait_drained(input int extra);
    while (taken_count != issued_count || expected_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // owners mostly from a small pool so that entries get hit, filled and emptied
  task automatic queue_random(input int n, input logic [7:0] base);
    int          r;
    logic [1:0]  kind;
    logic [7:0]  who;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = KIND_DOWN;
      else if (r < 75) kind = KIND_UP;
      else if (r < 92) kind = KIND_CLEAN;
      else kind = KIND_UNUSED;
      if ($urandom_range(0, 99) < 80) who = base + 8'($urandom_range(0, 19));
      else who = 8'($urandom_range(0, 255));
      queue_request(kind, who);
    end
  endtask

  initial begin
    logic [7:0] leftovers[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settings_count = 1;

    // reset values: limit 1, nothing available
    queue_request(KIND_DOWN, 8'h00);
    queue_request(KIND_UP, 8'hff);
    queue_request(KIND_UP, 8'hff);
    queue_request(KIND_UNUSED, 8'h55);
    queue_request(KIND_CLEAN, 8'haa);
    wait_drained(4);

    // start above the limit, fill the holder list and overflow it
    set_counts(16'd20, 16'd40);
    queue_request(KIND_DOWN, 8'h00);
    queue_request(KIND_DOWN, 8'hff);
    for (int k = 1; k <= 14; k++) queue_request(KIND_DOWN, 8'(k * 17));
    queue_request(KIND_DOWN, 8'h80);
    queue_request(KIND_DOWN, 8'hff);
    queue_request(KIND_CLEAN, 8'hff);
    queue_request(KIND_DOWN, 8'h00);
    queue_request(KIND_UP, 8'h80);
    wait_drained(4);

    // empty the list so the run below scans a single entry
    for (int i = 0; i < tbl_count; i++) leftovers.push_back(tbl_owner[i]);
    foreach (leftovers[i]) queue_request(KIND_CLEAN, leftovers[i]);
    wait_drained(4);

    // one owner takes a run of units back to back
    bulk_mode = 1'b1;
    set_counts(16'hffff, 16'hffff);
    for (int i = 0; i < 20; i++) queue_request(KIND_DOWN, 8'h5a);
    wait_drained(4);
    write_reg(REG_INIT, 16'd1);
    queue_request(KIND_DOWN, 8'h5a);
    queue_request(KIND_DOWN, 8'h5a);
    queue_request(KIND_CLEAN, 8'h5a);
    wait_drained(4);
    bulk_mode = 1'b0;

    set_counts(16'd1, 16'd1);
    queue_random(140, 8'($urandom_range(0, 255)));
    wait_drained(4);

    // receiver holds off while requests keep coming
    set_counts(16'd20, 16'd40);
    hold_request = 200;
    queue_random(140, 8'($urandom_range(0, 255)));
    wait_drained(4);

    set_counts(16'($urandom_range(16, 64)), 16'($urandom_range(0, 80)));
    queue_random(140, 8'($urandom_range(0, 255)));
    wait_drained(4);

    set_counts(16'hffff, 16'd0);
    queue_random(140, 8'($urandom_range(0, 255)));
    wait_drained(4);

    set_counts(16'd3, 16'hffff);
    queue_random(140, 8'($urandom_range(0, 255)));
    wait_drained(80);

    $display("%0d transactions checked across %0d register settings, %0d mismatches",
             results_seen, settings_count, error_count);
    $display("outcomes: %0d done, %0d would-block, %0d list full, %0d no effect, %0d wake-ups",
             status_tally[ST_DONE], status_tally[ST_BLOCK], status_tally[ST_FULL],
             status_tally[ST_NOEFF], wake_tally);
    if (error_count == 0) begin
      $display("counting_semaphore_with_holders regression: pass");
    end else begin
      $display("counting_semaphore_with_holders regression: fail");
    end
    $finish;
  end

  initial begin
    #32000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("counting_semaphore_with_holders regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
